[hdl/vfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types, constants and codes of the fixed-point vector unit.
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OPCODE_BITS = 4;
  localparam int STATUS_BITS = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DIV   = 4'd4,
    OP_CROSS = 4'd5,
    OP_DOT   = 4'd6,
    OP_LEN   = 4'd7,
    OP_UNIT  = 4'd8,
    OP_POINT = 4'd9,
    OP_NONE  = 4'd10
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]      opcode;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] b_w;
    logic signed [WORD_BITS-1:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] r_w;
    logic signed [WORD_BITS-1:0] scalar_out;
    logic [STATUS_BITS-1:0]      status;
  } out_item_t;

  // Classified request handed from the front end to the execution pipeline.
  typedef struct packed {
    op_e                        op;
    logic                       err;
    logic [2:0][WORD_BITS-1:0]  a;
    logic [2:0][WORD_BITS-1:0]  b;
    logic [WORD_BITS-1:0]       w;
    logic [WORD_BITS-1:0]       s;
    logic [5:0][WORD_BITS-1:0]  ma;
    logic [5:0][WORD_BITS-1:0]  mb;
  } dec_item_t;

endpackage

[hdl/vfa_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_stream_if
// Valid/ready stream channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface vfa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/vec3_fixed_point_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu
// Three-component vector unit in signed Q16.16 with saturating results.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per handshake: opcode, vectors a and b, weight
//   b_w and scalar_in. out_o returns one result per request, in order:
//   r_x/r_y/r_z, r_w, scalar_out and status (ok, zero divisor or zero
//   length, saturated).
//   An intake register classifies each request and pushes it into a
//   QUEUE_DEPTH-entry queue; the execution pipeline pops it and runs every
//   opcode through the same fixed path: multiply, sum, saturate, a 32-stage
//   square root, divider setup and a 32-stage divider, then the result
//   register. Throughput is one request per cycle while out_o does not
//   stall; the divider and root are fully pipelined, one bit per stage.
//   When out_o.valid is high and out_o.ready is low the whole execution
//   pipeline holds; in_i keeps accepting until the intake register and the
//   queue are full.
//   Reset clears all valid flags and the queue pointers; no results are
//   pending after reset.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu #(
  parameter int QUEUE_DEPTH = vfa_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vfa_stream_if.sink   in_i,
  vfa_stream_if.source out_o
);

  logic               push_valid, push_ready, pop_valid, pop_ready;
  vfa_pkg::dec_item_t push_data, pop_data;

  vfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  vfa_fifo #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (vfa_pkg::dec_item_t)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  vfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

[hdl/vfa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_front
// Request intake: decodes the opcode, flags zero divisors and zero vectors,
// and routes the multiplier operands.
// ----------------------------------------------------------------------------
module vfa_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  vfa_stream_if.sink                in_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output vfa_pkg::dec_item_t        push_data_o
);

  localparam int W = vfa_pkg::WORD_BITS;

  vfa_pkg::dec_item_t dec_d, dec_q;
  logic               valid_q;
  logic               take;
  vfa_pkg::in_item_t  req;
  logic [2:0][W-1:0]  av, bv;

  assign req  = in_i.payload;
  assign av   = {req.a_z, req.a_y, req.a_x};
  assign bv   = {req.b_z, req.b_y, req.b_x};
  assign in_i.ready = !valid_q || push_ready_i;
  assign take = in_i.valid && in_i.ready;

  always_comb begin
    dec_d    = '0;
    dec_d.a  = av;
    dec_d.b  = bv;
    dec_d.w  = req.b_w;
    dec_d.s  = req.scalar_in;
    if (req.opcode <= vfa_pkg::OPCODE_BITS'(vfa_pkg::OP_POINT)) begin
      dec_d.op = vfa_pkg::op_e'(req.opcode);
    end else begin
      dec_d.op = vfa_pkg::OP_NONE;
    end
    unique case (dec_d.op)
      vfa_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          dec_d.ma[2*i] = av[i];
          dec_d.mb[2*i] = req.scalar_in;
        end
      end
      vfa_pkg::OP_POINT: begin
        for (int i = 0; i < 3; i++) begin
          dec_d.ma[2*i] = av[i];
          dec_d.mb[2*i] = req.b_w;
        end
      end
      vfa_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          dec_d.ma[2*i] = av[i];
          dec_d.mb[2*i] = bv[i];
        end
      end
      vfa_pkg::OP_LEN, vfa_pkg::OP_UNIT: begin
        for (int i = 0; i < 3; i++) begin
          dec_d.ma[2*i] = av[i];
          dec_d.mb[2*i] = av[i];
        end
      end
      vfa_pkg::OP_CROSS: begin
        // lane i forms ma[2i]*mb[2i] - ma[2i+1]*mb[2i+1]
        dec_d.ma[0] = av[1]; dec_d.mb[0] = bv[2];
        dec_d.ma[1] = av[2]; dec_d.mb[1] = bv[1];
        dec_d.ma[2] = av[2]; dec_d.mb[2] = bv[0];
        dec_d.ma[3] = av[0]; dec_d.mb[3] = bv[2];
        dec_d.ma[4] = av[0]; dec_d.mb[4] = bv[1];
        dec_d.ma[5] = av[1]; dec_d.mb[5] = bv[0];
      end
      default: begin
      end
    endcase
    dec_d.err = ((dec_d.op == vfa_pkg::OP_DIV) && (req.scalar_in == '0)) ||
                ((dec_d.op == vfa_pkg::OP_UNIT) && (av == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dec_q <= dec_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = dec_q;

endmodule

[hdl/vfa_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_fifo
// Short request queue between intake and execution.
// ----------------------------------------------------------------------------
module vfa_fifo #(
  parameter int  DEPTH  = vfa_pkg::QUEUE_DEPTH,
  parameter type item_t = vfa_pkg::dec_item_t
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[hdl/vfa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_back
// Execution pipeline: multipliers, sums and saturation, a bit-per-stage
// square root, a bit-per-stage divider and the result register.
// ----------------------------------------------------------------------------
module vfa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  vfa_pkg::dec_item_t  pop_data_i,
  vfa_stream_if.source        out_o
);

  localparam int W    = vfa_pkg::WORD_BITS;
  localparam int F    = vfa_pkg::FRAC_BITS;
  localparam int PW   = 2 * W;
  localparam int SW   = PW + 2;
  localparam int REMW = W + 2;
  localparam int NSQ  = W;
  localparam int NDV  = W;
  localparam int SQ0  = 3;
  localparam int DV0  = SQ0 + NSQ;
  localparam int NSTG = DV0 + 1 + NDV;

  localparam logic signed [SW-1:0] MaxS = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] MinS = $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});
  localparam logic [W-1:0]         MaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         MinW = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    vfa_pkg::op_e       op;
    logic               err;
    logic [2:0][W-1:0]  a;
    logic [W-1:0]       w;
    logic [W-1:0]       s;
    logic [2:0][W-1:0]  er;
    logic [W-1:0]       esc;
    logic               esat;
    logic [W-1:0]       len;
  } carry_t;

  function automatic logic signed [SW-1:0] sx(input logic [W-1:0] v);
    sx = $signed({{(SW-W){v[W-1]}}, v});
  endfunction

  // {clamped, value}
  function automatic logic [W:0] sat_w(input logic signed [SW-1:0] v);
    if (v > MaxS) begin
      sat_w = {1'b1, MaxW};
    end else if (v < MinS) begin
      sat_w = {1'b1, MinW};
    end else begin
      sat_w = {1'b0, v[W-1:0]};
    end
  endfunction

  logic               en;
  logic [NSTG-1:0]    vld_q;

  // stage 1: products
  carry_t                  s1_d, s1_q;
  logic [2:0][W-1:0]       s1_b_q;
  logic signed [PW-1:0]    s1_p_q [6];
  // stage 2: lanes (cross differences or even products) and three-term sum
  carry_t                  s2_q;
  logic [2:0][W-1:0]       s2_b_q;
  logic signed [SW-1:0]    s2_lane_q [3];
  logic signed [SW-1:0]    s2_sum_q;
  // stage 3: shifted, saturated early results
  carry_t                  s3_d, s3_q;
  logic [PW-1:0]           s3_x_q;
  // square root stages
  carry_t                  sq_c_q    [NSQ];
  logic [PW-1:0]           sq_x_q    [NSQ];
  logic [REMW-1:0]         sq_rem_q  [NSQ];
  logic [W-1:0]            sq_root_q [NSQ];
  // divider setup
  carry_t                  dv_c_d, dv_c_q;
  logic [W-1:0]            dv_d_d, dv_d_q;
  logic [W-1:0]            dv_n_d   [3], dv_n_q   [3];
  logic [W-1:0]            dv_rem_d [3], dv_rem_q [3];
  logic [2:0]              dv_ovf_d, dv_ovf_q, dv_neg_d, dv_neg_q;
  // divider stages
  carry_t                  dp_c_q   [NDV];
  logic [W-1:0]            dp_d_q   [NDV];
  logic [W-1:0]            dp_n_q   [NDV][3];
  logic [W-1:0]            dp_rem_q [NDV][3];
  logic [W-1:0]            dp_quo_q [NDV][3];
  logic [2:0]              dp_ovf_q [NDV];
  logic [2:0]              dp_neg_q [NDV];
  // result
  vfa_pkg::out_item_t      res_d, res_q;
  logic                    out_valid_q;

  assign en          = !out_valid_q || out_o.ready;
  assign pop_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NSTG-2:0], pop_valid_i};
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  // stage 1
  always_comb begin
    s1_d     = '0;
    s1_d.op  = pop_data_i.op;
    s1_d.err = pop_data_i.err;
    s1_d.a   = pop_data_i.a;
    s1_d.w   = pop_data_i.w;
    s1_d.s   = pop_data_i.s;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      s1_b_q    <= pop_data_i.b;
      for (int k = 0; k < 6; k++) begin
        s1_p_q[k] <= $signed(pop_data_i.ma[k]) * $signed(pop_data_i.mb[k]);
      end
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q   <= s1_q;
      s2_b_q <= s1_b_q;
      for (int i = 0; i < 3; i++) begin
        if (s1_q.op == vfa_pkg::OP_CROSS) begin
          s2_lane_q[i] <= $signed({{2{s1_p_q[2*i][PW-1]}}, s1_p_q[2*i]}) -
                          $signed({{2{s1_p_q[2*i+1][PW-1]}}, s1_p_q[2*i+1]});
        end else begin
          s2_lane_q[i] <= $signed({{2{s1_p_q[2*i][PW-1]}}, s1_p_q[2*i]});
        end
      end
      s2_sum_q <= $signed({{2{s1_p_q[0][PW-1]}}, s1_p_q[0]}) +
                  $signed({{2{s1_p_q[2][PW-1]}}, s1_p_q[2]}) +
                  $signed({{2{s1_p_q[4][PW-1]}}, s1_p_q[4]});
    end
  end

  // stage 3: arithmetic shift gives the floor
  always_comb begin
    logic signed [SW-1:0] lin;
    logic [W:0]           sv;
    s3_d      = s2_q;
    s3_d.esat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      unique case (s2_q.op)
        vfa_pkg::OP_ADD:   lin = sx(s2_q.a[i]) + sx(s2_b_q[i]);
        vfa_pkg::OP_SUB:   lin = sx(s2_q.a[i]) - sx(s2_b_q[i]);
        vfa_pkg::OP_NEG:   lin = -sx(s2_q.a[i]);
        vfa_pkg::OP_SCALE,
        vfa_pkg::OP_CROSS: lin = s2_lane_q[i] >>> F;
        vfa_pkg::OP_POINT: lin = (s2_lane_q[i] >>> F) + sx(s2_b_q[i]);
        default:           lin = '0;
      endcase
      sv           = sat_w(lin);
      s3_d.er[i]   = sv[W-1:0];
      s3_d.esat    = s3_d.esat | sv[W];
    end
    if (s2_q.op == vfa_pkg::OP_DOT) begin
      lin = s2_sum_q >>> F;
    end else begin
      lin = '0;
    end
    sv        = sat_w(lin);
    s3_d.esc  = sv[W-1:0];
    s3_d.esat = s3_d.esat | sv[W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q   <= s3_d;
      s3_x_q <= s2_sum_q[PW-1:0];
    end
  end

  // square root: one result bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    carry_t          c_in;
    logic [PW-1:0]   x_in;
    logic [REMW-1:0] rem_in, t, trial;
    logic [W-1:0]    root_in;
    logic            ge;

    if (k == 0) begin : g_first
      assign c_in    = s3_q;
      assign x_in    = s3_x_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign c_in    = sq_c_q[k-1];
      assign x_in    = sq_x_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
    end

    assign t     = {rem_in[W-1:0], x_in[PW-1:PW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_c_q[k]    <= c_in;
        sq_x_q[k]    <= {x_in[PW-3:0], 2'b00};
        sq_rem_q[k]  <= ge ? (t - trial) : t;
        sq_root_q[k] <= {root_in[W-2:0], ge};
      end
    end
  end

  // divider setup: magnitudes, sign and quotient overflow
  always_comb begin
    logic [W-1:0] smag, amag, hi;
    dv_c_d     = sq_c_q[NSQ-1];
    dv_c_d.len = sq_root_q[NSQ-1];
    smag   = dv_c_d.s[W-1] ? (~dv_c_d.s + 1'b1) : dv_c_d.s;
    dv_d_d = (dv_c_d.op == vfa_pkg::OP_UNIT) ? sq_root_q[NSQ-1] : smag;
    for (int i = 0; i < 3; i++) begin
      amag        = dv_c_d.a[i][W-1] ? (~dv_c_d.a[i] + 1'b1) : dv_c_d.a[i];
      hi          = {{(W-F){1'b0}}, amag[W-1:W-F]};
      dv_ovf_d[i] = (hi >= dv_d_d);
      dv_rem_d[i] = dv_ovf_d[i] ? '0 : hi;
      dv_n_d[i]   = {amag[W-F-1:0], {F{1'b0}}};
      dv_neg_d[i] = dv_c_d.a[i][W-1] ^
                    ((dv_c_d.op == vfa_pkg::OP_DIV) && dv_c_d.s[W-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_c_q   <= dv_c_d;
      dv_d_q   <= dv_d_d;
      dv_n_q   <= dv_n_d;
      dv_rem_q <= dv_rem_d;
      dv_ovf_q <= dv_ovf_d;
      dv_neg_q <= dv_neg_d;
    end
  end

  // restoring divider: one quotient bit per stage, three lanes
  for (genvar k = 0; k < NDV; k++) begin : g_div
    carry_t       c_in;
    logic [W-1:0] d_in;
    logic [W-1:0] n_in   [3];
    logic [W-1:0] rem_in [3];
    logic [W-1:0] quo_in [3];
    logic [2:0]   ovf_in, neg_in;

    if (k == 0) begin : g_first
      assign c_in   = dv_c_q;
      assign d_in   = dv_d_q;
      assign n_in   = dv_n_q;
      assign rem_in = dv_rem_q;
      assign quo_in = '{default: '0};
      assign ovf_in = dv_ovf_q;
      assign neg_in = dv_neg_q;
    end else begin : g_next
      assign c_in   = dp_c_q[k-1];
      assign d_in   = dp_d_q[k-1];
      assign n_in   = dp_n_q[k-1];
      assign rem_in = dp_rem_q[k-1];
      assign quo_in = dp_quo_q[k-1];
      assign ovf_in = dp_ovf_q[k-1];
      assign neg_in = dp_neg_q[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [W:0] t, diff;
      logic       ge;

      assign t    = {rem_in[i], n_in[i][W-1]};
      assign ge   = (t >= {1'b0, d_in});
      assign diff = t - {1'b0, d_in};

      always_ff @(posedge clk_i) begin
        if (en) begin
          dp_n_q[k][i]   <= {n_in[i][W-2:0], 1'b0};
          dp_rem_q[k][i] <= ge ? diff[W-1:0] : t[W-1:0];
          dp_quo_q[k][i] <= {quo_in[i][W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dp_c_q[k]   <= c_in;
        dp_d_q[k]   <= d_in;
        dp_ovf_q[k] <= ovf_in;
        dp_neg_q[k] <= neg_in;
      end
    end
  end

  // result select
  always_comb begin
    carry_t       c;
    logic [W-1:0] q;
    logic [W-1:0] r [3];
    logic [W-1:0] sc;
    logic         satf;
    c    = dp_c_q[NDV-1];
    q    = '0;
    for (int i = 0; i < 3; i++) begin
      r[i] = c.er[i];
    end
    sc   = c.esc;
    satf = c.esat;
    unique case (c.op)
      vfa_pkg::OP_DIV, vfa_pkg::OP_UNIT: begin
        satf = 1'b0;
        sc   = '0;
        for (int i = 0; i < 3; i++) begin
          q = dp_quo_q[NDV-1][i];
          if (dp_neg_q[NDV-1][i]) begin
            if (dp_ovf_q[NDV-1][i] || (q > MinW)) begin
              r[i] = MinW;
              satf = 1'b1;
            end else begin
              r[i] = ~q + 1'b1;
            end
          end else begin
            if (dp_ovf_q[NDV-1][i] || q[W-1]) begin
              r[i] = MaxW;
              satf = 1'b1;
            end else begin
              r[i] = q;
            end
          end
        end
      end
      vfa_pkg::OP_LEN: begin
        r    = '{default: '0};
        satf = c.len[W-1];
        sc   = c.len[W-1] ? MaxW : c.len;
      end
      default: begin
      end
    endcase

    res_d.r_x        = r[0];
    res_d.r_y        = r[1];
    res_d.r_z        = r[2];
    res_d.r_w        = (c.op == vfa_pkg::OP_POINT) ? c.w : '0;
    res_d.scalar_out = sc;
    res_d.status     = satf ? vfa_pkg::ST_SAT : vfa_pkg::ST_OK;
    if (c.err) begin
      res_d        = '0;
      res_d.status = vfa_pkg::ST_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = res_q;

endmodule

[tb/vec3_fixed_point_alu_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu_tb
// Self-checking bench for the Q16.16 vector unit.
// A directed table covers the field extremes, every opcode and the error and
// saturation cases. Random requests follow under several idling phases. Each
// result is checked in order against a bit-exact predictor.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu_tb;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_CYCLES = 150;
  localparam int  N_RANDOM = 830;
  localparam int  N_HOLD = 120;
  localparam logic [31:0] QMAX = 32'h7fffffff;
  localparam logic [31:0] QMIN = 32'h80000000;
  localparam logic [31:0] QONE = 32'h00010000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vfa_stream_if #(.payload_t(vfa_pkg::in_item_t))  req_if ();
  vfa_stream_if #(.payload_t(vfa_pkg::out_item_t)) res_if ();

  vec3_fixed_point_alu dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (res_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  vfa_pkg::out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        recv_hold = 1'b0;
  bit        drain_done = 1'b0;

  // Saturate a wide value to the 32-bit signed range.
  function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                    inout bit clamped);
    if (v > 128'sd2147483647) begin
      clamped = 1'b1;
      return QMAX;
    end
    if (v < -128'sd2147483648) begin
      clamped = 1'b1;
      return QMIN;
    end
    return v[31:0];
  endfunction

  // Truncating divide on 128-bit signed values.
  function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic signed [127:0] q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] x);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'h1_0000_0000_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= x) lo = mid;
      else hi = mid;
    end
    return lo[63:0];
  endfunction

  function automatic vfa_pkg::out_item_t predict_vec_op(input vfa_pkg::in_item_t rq);
    vfa_pkg::out_item_t  r;
    logic signed [127:0] a[3], b[3], w, s, len;
    logic [127:0]        sq;
    bit                  clamped, err;
    r = '0;
    clamped = 1'b0;
    err = 1'b0;
    a[0] = rq.a_x; a[1] = rq.a_y; a[2] = rq.a_z;
    b[0] = rq.b_x; b[1] = rq.b_y; b[2] = rq.b_z;
    w = rq.b_w;
    s = rq.scalar_in;
    case (rq.opcode)
      vfa_pkg::OP_ADD: begin
        r.r_x = clamp_word(a[0] + b[0], clamped);
        r.r_y = clamp_word(a[1] + b[1], clamped);
        r.r_z = clamp_word(a[2] + b[2], clamped);
      end
      vfa_pkg::OP_SUB: begin
        r.r_x = clamp_word(a[0] - b[0], clamped);
        r.r_y = clamp_word(a[1] - b[1], clamped);
        r.r_z = clamp_word(a[2] - b[2], clamped);
      end
      vfa_pkg::OP_NEG: begin
        r.r_x = clamp_word(-a[0], clamped);
        r.r_y = clamp_word(-a[1], clamped);
        r.r_z = clamp_word(-a[2], clamped);
      end
      vfa_pkg::OP_SCALE: begin
        r.r_x = clamp_word((a[0] * s) >>> vfa_pkg::FRAC_BITS, clamped);
        r.r_y = clamp_word((a[1] * s) >>> vfa_pkg::FRAC_BITS, clamped);
        r.r_z = clamp_word((a[2] * s) >>> vfa_pkg::FRAC_BITS, clamped);
      end
      vfa_pkg::OP_DIV: begin
        if (s == 0) err = 1'b1;
        else begin
          r.r_x = clamp_word(div_trunc(a[0] <<< vfa_pkg::FRAC_BITS, s), clamped);
          r.r_y = clamp_word(div_trunc(a[1] <<< vfa_pkg::FRAC_BITS, s), clamped);
          r.r_z = clamp_word(div_trunc(a[2] <<< vfa_pkg::FRAC_BITS, s), clamped);
        end
      end
      vfa_pkg::OP_CROSS: begin
        r.r_x = clamp_word((a[1] * b[2] - a[2] * b[1]) >>> vfa_pkg::FRAC_BITS, clamped);
        r.r_y = clamp_word((a[2] * b[0] - a[0] * b[2]) >>> vfa_pkg::FRAC_BITS, clamped);
        r.r_z = clamp_word((a[0] * b[1] - a[1] * b[0]) >>> vfa_pkg::FRAC_BITS, clamped);
      end
      vfa_pkg::OP_DOT: begin
        r.scalar_out = clamp_word((a[0] * b[0] + a[1] * b[1] + a[2] * b[2])
                                  >>> vfa_pkg::FRAC_BITS, clamped);
      end
      vfa_pkg::OP_LEN, vfa_pkg::OP_UNIT: begin
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = root_floor(sq);
        if (rq.opcode == vfa_pkg::OP_LEN) r.scalar_out = clamp_word(len, clamped);
        else if (len == 0) err = 1'b1;
        else begin
          r.r_x = clamp_word(div_trunc(a[0] <<< vfa_pkg::FRAC_BITS, len), clamped);
          r.r_y = clamp_word(div_trunc(a[1] <<< vfa_pkg::FRAC_BITS, len), clamped);
          r.r_z = clamp_word(div_trunc(a[2] <<< vfa_pkg::FRAC_BITS, len), clamped);
        end
      end
      vfa_pkg::OP_POINT: begin
        r.r_x = clamp_word(((a[0] * w) >>> vfa_pkg::FRAC_BITS) + b[0], clamped);
        r.r_y = clamp_word(((a[1] * w) >>> vfa_pkg::FRAC_BITS) + b[1], clamped);
        r.r_z = clamp_word(((a[2] * w) >>> vfa_pkg::FRAC_BITS) + b[2], clamped);
        r.r_w = rq.b_w;
      end
      default: ;
    endcase
    if (err) begin
      r = '0;
      r.status = vfa_pkg::ST_ZERO;
    end else begin
      r.status = clamped ? vfa_pkg::ST_SAT : vfa_pkg::ST_OK;
    end
    return r;
  endfunction

  // Directed rows; check_fixed marks rows whose result is typed in.
  typedef struct {
    vfa_pkg::in_item_t  rq;
    bit                 check_fixed;
    vfa_pkg::out_item_t fixed;
  } vec_row_t;

  vec_row_t directed_rows[$];

  function automatic vfa_pkg::in_item_t make_req(input logic [3:0] op,
                                                 input logic [31:0] ax, ay, az,
                                                 input logic [31:0] bx, by, bz, bw, s);
    vfa_pkg::in_item_t rq;
    rq.opcode = op;
    rq.a_x = ax; rq.a_y = ay; rq.a_z = az;
    rq.b_x = bx; rq.b_y = by; rq.b_z = bz;
    rq.b_w = bw; rq.scalar_in = s;
    return rq;
  endfunction

  function automatic vfa_pkg::out_item_t make_res(input logic [31:0] x, y, z, w, sc,
                                                  input vfa_pkg::status_e st);
    vfa_pkg::out_item_t r;
    r.r_x = x; r.r_y = y; r.r_z = z; r.r_w = w; r.scalar_out = sc; r.status = st;
    return r;
  endfunction

  task automatic add_row(input vfa_pkg::in_item_t rq, input bit fixed_ok,
                         input vfa_pkg::out_item_t fx);
    vec_row_t row;
    row.rq = rq;
    row.check_fixed = fixed_ok;
    row.fixed = fx;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    vfa_pkg::out_item_t nil;
    nil = '0;
    add_row(make_req(vfa_pkg::OP_ADD, QMAX, QMIN, 1, 1, -1, 2, 0, 0), 1,
            make_res(QMAX, QMIN, 3, 0, 0, vfa_pkg::ST_SAT));
    add_row(make_req(vfa_pkg::OP_ADD, 5, 6, 7, 1, 2, 3, 9, 9), 1,
            make_res(6, 8, 10, 0, 0, vfa_pkg::ST_OK));
    add_row(make_req(vfa_pkg::OP_SUB, QMIN, QMAX, 0, 1, -1, 0, 0, 0), 1,
            make_res(QMIN, QMAX, 0, 0, 0, vfa_pkg::ST_SAT));
    add_row(make_req(vfa_pkg::OP_NEG, QMIN, 1, QMAX, 0, 0, 0, 0, 0), 1,
            make_res(QMAX, -1, -32'sd2147483647, 0, 0, vfa_pkg::ST_SAT));
    add_row(make_req(vfa_pkg::OP_SCALE, QONE, -QONE, QMAX, 0, 0, 0, 0, 2 * QONE), 0, nil);
    add_row(make_req(vfa_pkg::OP_SCALE, -1, 3, 5, 0, 0, 0, 0, 1), 0, nil);
    add_row(make_req(vfa_pkg::OP_DIV, 1, 2, 3, 0, 0, 0, 0, 0), 1,
            make_res(0, 0, 0, 0, 0, vfa_pkg::ST_ZERO));
    add_row(make_req(vfa_pkg::OP_DIV, QMAX, -7, QMIN, 0, 0, 0, 0, 1), 0, nil);
    add_row(make_req(vfa_pkg::OP_DIV, QMIN, 7, -7, 0, 0, 0, 0, -1), 0, nil);
    add_row(make_req(vfa_pkg::OP_DIV, 3 * QONE, -3, 5, 0, 0, 0, 0, 2 * QONE), 0, nil);
    add_row(make_req(vfa_pkg::OP_CROSS, QONE, 0, 0, 0, QONE, 0, 0, 0), 1,
            make_res(0, 0, QONE, 0, 0, vfa_pkg::ST_OK));
    add_row(make_req(vfa_pkg::OP_CROSS, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, 0, 0), 0, nil);
    add_row(make_req(vfa_pkg::OP_DOT, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0, 0), 1,
            make_res(0, 0, 0, 0, QMAX, vfa_pkg::ST_SAT));
    add_row(make_req(vfa_pkg::OP_DOT, -1, 1, 3, 1, 1, 7, 0, 0), 0, nil);
    add_row(make_req(vfa_pkg::OP_LEN, 3 * QONE, 4 * QONE, 0, 0, 0, 0, 0, 0), 1,
            make_res(0, 0, 0, 0, 5 * QONE, vfa_pkg::ST_OK));
    add_row(make_req(vfa_pkg::OP_LEN, QMIN, QMIN, QMIN, 0, 0, 0, 0, 0), 1,
            make_res(0, 0, 0, 0, QMAX, vfa_pkg::ST_SAT));
    add_row(make_req(vfa_pkg::OP_UNIT, 0, 0, 0, 1, 1, 1, 1, 1), 1,
            make_res(0, 0, 0, 0, 0, vfa_pkg::ST_ZERO));
    add_row(make_req(vfa_pkg::OP_UNIT, 0, 1, 0, 0, 0, 0, 0, 0), 1,
            make_res(0, QONE, 0, 0, 0, vfa_pkg::ST_OK));
    add_row(make_req(vfa_pkg::OP_UNIT, QMAX, QMIN, 12345, 0, 0, 0, 0, 0), 0, nil);
    add_row(make_req(vfa_pkg::OP_POINT, QONE, 2, -3, 10, QMAX, QMIN, QONE, 0), 0, nil);
    add_row(make_req(vfa_pkg::OP_POINT, QMAX, QMIN, 1, QMAX, QMIN, 0, QMIN, 0), 0, nil);
    add_row(make_req(vfa_pkg::OP_NONE, QMAX, 1, 2, 3, 4, 5, 6, 7), 1, nil);
    add_row(make_req(4'd15, -1, -1, -1, -1, -1, -1, -1, -1), 1, nil);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return QMAX;
      1: return QMIN;
      2: return 32'($urandom_range(0, 4));
      3: return -32'($urandom_range(0, 4));
      4, 5: return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vfa_pkg::in_item_t rand_req();
    vfa_pkg::in_item_t rq;
    rq.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
    rq.a_x = rand_word(); rq.a_y = rand_word(); rq.a_z = rand_word();
    rq.b_x = rand_word(); rq.b_y = rand_word(); rq.b_z = rand_word();
    rq.b_w = rand_word(); rq.scalar_in = rand_word();
    if ($urandom_range(0, 9) == 0) begin
      rq.a_x = 0; rq.a_y = 0; rq.a_z = 0;
    end
    return rq;
  endfunction

  // Keep valid high across back-to-back requests; drop it only while idle.
  task automatic send_req(input vfa_pkg::in_item_t rq);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Send one request and queue what it must return.
  task automatic issue(input vfa_pkg::in_item_t rq, input bit fixed_ok,
                       input vfa_pkg::out_item_t fx);
    vfa_pkg::out_item_t exp_r;
    exp_r = predict_vec_op(rq);
    if (fixed_ok && exp_r !== fx) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("table row disagrees with predictor: table %h predictor %h", fx, exp_r);
    end
    pending_results.push_back(fixed_ok ? fx : exp_r);
    send_req(rq);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) issue(rand_req(), 0, '0);
  endtask

  // Receiver ready, with random stalls and an optional long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !recv_hold && !(recv_stall_pct > 0 &&
                                      $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    vfa_pkg::out_item_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", res_if.payload);
      end else begin
        exp_r = pending_results.pop_front();
        if (res_if.payload.r_x !== exp_r.r_x || res_if.payload.r_y !== exp_r.r_y ||
            res_if.payload.r_z !== exp_r.r_z || res_if.payload.r_w !== exp_r.r_w ||
            res_if.payload.scalar_out !== exp_r.scalar_out ||
            res_if.payload.status !== exp_r.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %h actual %h", exp_r, res_if.payload);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Long receiver hold while the sender keeps offering requests.
  initial begin
    wait (recv_hold);
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.payload = '0;
    build_directed();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i])
      issue(directed_rows[i].rq, directed_rows[i].check_fixed, directed_rows[i].fixed);
    recv_hold = 1'b1;
    random_phase(N_HOLD, 0, 0);
    wait_drained();
    random_phase(N_RANDOM / 5, 0, 0);
    random_phase(N_RANDOM / 5, 65, 0);
    wait_drained();
    random_phase(N_RANDOM / 5, 0, 65);
    random_phase(N_RANDOM / 5, 12, 12);
    random_phase(N_RANDOM / 5 - N_HOLD, 0, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    drain_done = 1'b1;
  end

  initial begin
    wait (drain_done);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
